FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define FTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define FTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, always on.
`define FTL_ASSERT_NXT_ANY(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ftl_pkg.sv
// Shared types and constants of the falling trail renderer.
package ftl_pkg;

    localparam int DEF_NUM_TRAILS     = 32;
    localparam int DEF_NUM_COLUMNS    = 30;
    localparam int DEF_NUM_ROWS       = 6;
    localparam int DEF_SUBPIXEL_STEPS = 256;

    localparam int IDX_IN_W  = 5;
    localparam int RND_W     = 21;
    localparam int COL_W     = 8;
    localparam int SPEED_W   = 7;
    localparam int LEN_W     = 6;

    localparam int ROW_OUT_W = 3;
    localparam int COL_OUT_W = 5;
    localparam int RED_W     = 9;
    localparam int GREEN_W   = 11;

    localparam int SPEED_BASE  = 10;
    localparam int LEN_BASE    = 4;
    localparam int SPEED_MAX   = 8'h3f + SPEED_BASE;
    localparam int LEN_MAX     = 8'h1f + LEN_BASE;
    localparam int FACTOR_BIAS = 9;

    localparam int GREEN_FULL  = 1024;
    localparam int GREEN_SLOPE = 992;
    localparam int QUOT_W      = 10;
    localparam int QUOT_PER_CYC = 2;
    localparam int LEVEL_SHIFT = 8;   // divide by 4*32*2
    localparam int PROD_W      = GREEN_W + SPEED_W;

    localparam int FIFO_DEPTH  = 4;

    typedef enum logic {
        ACT_RESPAWN = 1'b0,
        ACT_ADVANCE = 1'b1
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [IDX_IN_W-1:0]  idx;
        logic [COL_W-1:0]     col;
        logic [SPEED_W-1:0]   speed;
        logic [LEN_W-1:0]     len;
    } t_cmd;

endpackage

FILE: rtl/ftl_front.sv
// Input side: takes transactions, drops out-of-table ones, derives seed fields.
module ftl_front import ftl_pkg::*; #(
    parameter int NUM_TRAILS  = DEF_NUM_TRAILS,
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_action,
    input  logic [IDX_IN_W-1:0] i_trail_index,
    input  logic [RND_W-1:0]    i_random_word,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_full
);

    logic [15:0] w_mod;
    logic        w_in_range;
    logic        r_busy_seen;

    // Column seed modulo by constant: eight compare-subtract steps.
    always_comb begin
        w_mod = {8'b0, i_random_word[7:0]};
        for (int k = 7; k >= 0; k--) begin
            if (w_mod >= (16'(NUM_COLUMNS) << k)) begin
                w_mod = w_mod - (16'(NUM_COLUMNS) << k);
            end
        end
    end

    assign w_in_range = 9'(i_trail_index) < 9'(NUM_TRAILS);

    assign o_stall = i_full || !r_busy_seen;
    assign o_push  = i_valid && !o_stall && w_in_range;

    always_comb begin
        o_cmd.action = t_action'(i_action);
        o_cmd.idx    = i_trail_index;
        o_cmd.col    = w_mod[COL_W-1:0];
        o_cmd.speed  = SPEED_W'(i_random_word[13:8]) + SPEED_W'(SPEED_BASE);
        o_cmd.len    = LEN_W'(i_random_word[20:16]) + LEN_W'(LEN_BASE);
    end

    // Hold off the first cycle out of reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_seen <= 1'b0;
        end else begin
            r_busy_seen <= 1'b1;
        end
    end

endmodule

FILE: rtl/ftl_fifo.sv
// Command queue between the input side and the render engine.
module ftl_fifo import ftl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd             r_store [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_store[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule

FILE: rtl/ftl_back.sv
// Render engine: trail table, position update, row scan, divider, multiply and output register.
module ftl_back import ftl_pkg::*; #(
    parameter int NUM_TRAILS     = DEF_NUM_TRAILS,
    parameter int NUM_ROWS       = DEF_NUM_ROWS,
    parameter int SUBPIXEL_STEPS = DEF_SUBPIXEL_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ROW_OUT_W-1:0] o_row,
    output logic [COL_OUT_W-1:0] o_column,
    output logic [RED_W-1:0]     o_red_level,
    output logic [GREEN_W-1:0]   o_green_level,
    output logic [RED_W-1:0]     o_blue_level,
    output logic                 o_last_pixel
);

    localparam int IDX_W   = (NUM_TRAILS > 1) ? $clog2(NUM_TRAILS) : 1;
    localparam int POS_MAX = (LEN_MAX + NUM_ROWS) * SUBPIXEL_STEPS + SPEED_MAX;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int SPAN_W  = $clog2(LEN_MAX * SUBPIXEL_STEPS + 1);
    localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int DIV_W   = SPAN_W + QUOT_W;
    localparam int DIV_CYC = QUOT_W / QUOT_PER_CYC;
    localparam int CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [POS_W-1:0]   pos;
        logic [SPEED_W-1:0] speed;
        logic [LEN_W-1:0]   len;
    } t_trail;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_ROW,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state;

    t_trail          r_mem [NUM_TRAILS];
    logic [NUM_TRAILS-1:0] r_vld;
    t_trail          r_rd_data;
    logic            r_rd_vld;
    t_cmd            r_cmd;

    logic [COL_W-1:0]   r_col;
    logic [SPEED_W-1:0] r_factor;
    logic [SPAN_W-1:0]  r_span;
    logic [POS_W-1:0]   r_rowpos;
    logic [ROW_W-1:0]   r_row;
    logic               r_last;
    logic [SPAN_W-1:0]  r_rem;
    logic [QUOT_W-1:0]  r_dlo;
    logic [QUOT_W-1:0]  r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic [GREEN_W-1:0] r_green;
    logic [PROD_W-1:0]  r_prod;

    logic [7:0]         w_idx_ext;
    logic [IDX_W-1:0]   w_raddr;
    logic [IDX_W-1:0]   w_waddr;
    logic               w_we;
    t_trail             w_cur;
    t_trail             w_seed;
    t_trail             n_entry;
    logic [POS_W:0]     w_sum;
    logic [POS_W:0]     w_limit;
    logic [SPAN_W-1:0]  n_span;
    logic [SPEED_W-1:0] n_factor;
    logic               w_lit;
    logic               w_end;
    logic [DIV_W-1:0]   w_dividend;
    logic [SPAN_W:0]    n_trial;
    logic [SPAN_W-1:0]  n_rem;
    logic [QUOT_W-1:0]  n_dlo;
    logic [QUOT_PER_CYC-1:0] n_qbits;
    logic [GREEN_W-1:0] n_green;
    logic               w_out_free;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign w_idx_ext = 8'(i_cmd.idx);
    assign w_raddr   = w_idx_ext[IDX_W-1:0];
    assign w_waddr   = IDX_W'(8'(r_cmd.idx));
    assign w_we      = r_state == S_UPD;

    // Table update for the current command.
    always_comb begin
        w_cur  = r_rd_vld ? r_rd_data : '0;
        w_seed = '{col: r_cmd.col, pos: '0, speed: r_cmd.speed, len: r_cmd.len};
        w_sum  = (POS_W+1)'(w_cur.pos) + (POS_W+1)'(w_cur.speed);
        w_limit = ((POS_W+1)'(w_cur.len) + (POS_W+1)'(NUM_ROWS))
                  * (POS_W+1)'(SUBPIXEL_STEPS);
        if (r_cmd.action == ACT_RESPAWN || w_sum >= w_limit) begin
            n_entry = w_seed;
        end else begin
            n_entry     = w_cur;
            n_entry.pos = w_sum[POS_W-1:0];
        end
        n_span   = SPAN_W'(n_entry.len) * SPAN_W'(SUBPIXEL_STEPS);
        n_factor = (n_entry.speed >= SPEED_W'(FACTOR_BIAS))
                   ? SPEED_W'(n_entry.speed - SPEED_W'(FACTOR_BIAS)) : '0;
    end

    // Row scan: lit rows are contiguous, the last one is the bottom row
    // or the one whose next row would lie above the head.
    assign w_lit = r_rowpos < POS_W'(r_span);
    assign w_end = (r_row == ROW_W'(NUM_ROWS - 1)) || (r_rowpos < POS_W'(SUBPIXEL_STEPS));
    assign w_dividend = DIV_W'(r_rowpos[SPAN_W-1:0]) * DIV_W'(GREEN_SLOPE);

    // Restoring divider, two quotient bits per cycle.
    always_comb begin
        n_rem   = r_rem;
        n_dlo   = r_dlo;
        n_trial = '0;
        n_qbits = '0;
        for (int k = QUOT_PER_CYC - 1; k >= 0; k--) begin
            n_trial = {n_rem, n_dlo[QUOT_W-1]};
            n_dlo   = {n_dlo[QUOT_W-2:0], 1'b0};
            if (n_trial >= (SPAN_W+1)'(r_span)) begin
                n_trial    = n_trial - (SPAN_W+1)'(r_span);
                n_qbits[k] = 1'b1;
            end
            n_rem = n_trial[SPAN_W-1:0];
        end
    end

    assign n_green    = GREEN_W'(GREEN_FULL) - GREEN_W'(r_quot);
    assign w_out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= n_entry;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd    <= i_cmd;
                        r_rd_vld <= r_vld[w_raddr];
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_col    <= n_entry.col;
                    r_factor <= n_factor;
                    r_span   <= n_span;
                    r_rowpos <= n_entry.pos;
                    r_row    <= '0;
                    r_state  <= (r_cmd.action == ACT_ADVANCE) ? S_ROW : S_IDLE;
                end
                S_ROW: begin
                    if (w_lit) begin
                        r_last  <= w_end;
                        r_rem   <= w_dividend[DIV_W-1:QUOT_W];
                        r_dlo   <= w_dividend[QUOT_W-1:0];
                        r_quot  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (w_end) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_rowpos <= POS_W'(r_rowpos - POS_W'(SUBPIXEL_STEPS));
                        r_row    <= ROW_W'(r_row + 1'b1);
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_dlo  <= n_dlo;
                    r_quot <= {r_quot[QUOT_W-QUOT_PER_CYC-1:0], n_qbits};
                    r_cnt  <= CNT_W'(r_cnt + 1'b1);
                    if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_green <= n_green;
                    r_prod  <= PROD_W'(n_green) * PROD_W'(r_factor);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_valid       <= 1'b1;
                        o_row         <= ROW_OUT_W'(r_row);
                        o_column      <= r_col[COL_OUT_W-1:0];
                        o_red_level   <= r_prod[LEVEL_SHIFT+RED_W-1:LEVEL_SHIFT];
                        o_blue_level  <= r_prod[LEVEL_SHIFT+RED_W-1:LEVEL_SHIFT];
                        o_green_level <= r_green;
                        o_last_pixel  <= r_last;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rowpos <= POS_W'(r_rowpos - POS_W'(SUBPIXEL_STEPS));
                            r_row    <= ROW_W'(r_row + 1'b1);
                            r_state  <= S_ROW;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/falling_trail_led_renderer_unit.sv
// Falling trail renderer top level: input side, command queue, render engine.
// Each transaction names one trail; respawn reseeds it, advance moves it down and
// emits one pixel per covered row (ascending, last one flagged). Transactions go into a
// four-entry queue, so the input keeps accepting while the engine works or the output
// stalls, until the queue fills. The engine handles one command at a time: a respawn
// reads and rewrites its table entry, an advance does the same and then scans the rows,
// skipping unlit ones; each lit row goes through the restoring divider (two quotient bits
// a cycle), the colour multiply and the output register. The trail table reads as zero
// until a trail is first written; no clearing pass is needed.
module falling_trail_led_renderer_unit import ftl_pkg::*; #(
    parameter int NUM_TRAILS     = DEF_NUM_TRAILS,
    parameter int NUM_COLUMNS    = DEF_NUM_COLUMNS,
    parameter int NUM_ROWS       = DEF_NUM_ROWS,
    parameter int SUBPIXEL_STEPS = DEF_SUBPIXEL_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [IDX_IN_W-1:0]  i_trail_index,
    input  logic [RND_W-1:0]     i_random_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ROW_OUT_W-1:0] o_row,
    output logic [COL_OUT_W-1:0] o_column,
    output logic [RED_W-1:0]     o_red_level,
    output logic [GREEN_W-1:0]   o_green_level,
    output logic [RED_W-1:0]     o_blue_level,
    output logic                 o_last_pixel
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    ftl_front #(
        .NUM_TRAILS  (NUM_TRAILS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_action      (i_action),
        .i_trail_index (i_trail_index),
        .i_random_word (i_random_word),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_full        (w_full)
    );

    ftl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_cmd),
        .o_empty (w_empty)
    );

    ftl_back #(
        .NUM_TRAILS     (NUM_TRAILS),
        .NUM_ROWS       (NUM_ROWS),
        .SUBPIXEL_STEPS (SUBPIXEL_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_cmd         (w_head_cmd),
        .o_pop         (w_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_row         (o_row),
        .o_column      (o_column),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

FILE: rtl/ftl_checker.sv
// Port-level checks on the falling trail renderer, bound to the top level.
`include "assert_macros.svh"

module ftl_checker import ftl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_in_stall,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [ROW_OUT_W-1:0] o_row,
    input  logic [COL_OUT_W-1:0] o_column,
    input  logic [RED_W-1:0]     o_red_level,
    input  logic [GREEN_W-1:0]   o_green_level,
    input  logic [RED_W-1:0]     o_blue_level,
    input  logic                 o_last_pixel
);

    `FTL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_row) && $stable(o_column) && $stable(o_green_level) && $stable(o_red_level) && $stable(o_last_pixel), "stalled output transaction changed")
    `FTL_ASSERT_IMP(a_green_range, i_clk, i_rst_n, o_out_valid, (o_green_level <= GREEN_W'(GREEN_FULL)) && (o_green_level > GREEN_W'(GREEN_FULL - GREEN_SLOPE)), "green level out of range")
    `FTL_ASSERT_IMP(a_red_blue, i_clk, i_rst_n, o_out_valid, (o_red_level == o_blue_level) && (o_red_level <= RED_W'(o_green_level >> 2)), "red or blue level inconsistent with green")
    `FTL_ASSERT_NXT_ANY(a_reset_idle, i_clk, !i_rst_n, !o_out_valid && o_in_stall, "output valid or input open right after reset")

endmodule

bind falling_trail_led_renderer_unit ftl_checker u_ftl_checker (.*);
